FILE: rtl/core/plc_pkg.sv
package plc_pkg;

  // Default table depth
  localparam int unsigned NUM_INSTRUMENTS_DEF = 256;

  // Field widths
  localparam int unsigned OP_W       = 2;
  localparam int unsigned INSTR_W    = 16;
  localparam int unsigned QTY_W      = 20;
  localparam int unsigned PRICE_W    = 31;
  localparam int unsigned POS_W      = 32;
  localparam int unsigned NET_LIM_W  = 30;
  localparam int unsigned NOTL_LIM_W = 52;
  localparam int unsigned PROD_W     = 50;  // 30-bit positive price times 20-bit quantity
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = NOTL_LIM_W;
  localparam int unsigned SUM_W      = POS_W + 2;

  typedef enum logic [OP_W-1:0] {
    OP_RESERVE = 2'd0,
    OP_CANCEL  = 2'd1,
    OP_QUERY   = 2'd2
  } plc_op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NET_LIMIT      = 1'b0,
    CFG_NOTIONAL_LIMIT = 1'b1
  } plc_cfg_e;

  // Decoded request held between input register and evaluation
  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic               in_range;
    logic [INSTR_W-1:0] idx;
    logic               sell;
    logic [QTY_W-1:0]   qty;
    logic               notional_chk;
    logic [PROD_W-1:0]  product;
  } plc_s1_t;

  // Table write request
  typedef struct packed {
    logic               en;
    logic [INSTR_W-1:0] idx;
    logic [POS_W-1:0]   data;
  } plc_wr_t;

endpackage

FILE: rtl/core/plc_if.sv
interface plc_req_if;
  logic                                 valid;
  logic                                 ready;
  logic [plc_pkg::OP_W-1:0]             operation;
  logic [plc_pkg::INSTR_W-1:0]          instrument;
  logic                                 side;
  logic [plc_pkg::QTY_W-1:0]            quantity;
  logic signed [plc_pkg::PRICE_W-1:0]   price;

  modport source (output valid, operation, instrument, side, quantity, price, input ready);
  modport sink   (input valid, operation, instrument, side, quantity, price, output ready);
endinterface

interface plc_rsp_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 accepted;
  logic signed [plc_pkg::POS_W-1:0]     position;

  modport source (output valid, accepted, position, input ready);
  modport sink   (input valid, accepted, position, output ready);
endinterface

FILE: rtl/core/plc_table.sv
module plc_table #(
  parameter int unsigned NumInstruments = plc_pkg::NUM_INSTRUMENTS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          rd_en_i,
  input  logic [plc_pkg::INSTR_W-1:0]   rd_idx_i,
  input  plc_pkg::plc_wr_t              wr_i,
  output logic                          clearing_o,
  output logic [plc_pkg::POS_W-1:0]     rd_data_o
);

  localparam int unsigned IdxW = (NumInstruments > 1) ? $clog2(NumInstruments) : 1;

  logic [plc_pkg::POS_W-1:0] mem_q [NumInstruments];
  logic [plc_pkg::POS_W-1:0] rd_q;
  logic [IdxW-1:0]           rd_idx_q;

  logic                      clr_q, clr_d;
  logic [IdxW-1:0]           clr_cnt_q, clr_cnt_d;

  logic                      fwd_vld_q;
  logic [IdxW-1:0]           fwd_idx_q;
  logic [plc_pkg::POS_W-1:0] fwd_data_q;

  // Clearing sweep after reset, one entry per cycle
  always_comb begin
    clr_d     = clr_q;
    clr_cnt_d = clr_cnt_q;
    if (clr_q) begin
      if (clr_cnt_q == IdxW'(NumInstruments - 1)) begin
        clr_d = 1'b0;
      end else begin
        clr_cnt_d = clr_cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
    end else begin
      clr_q     <= clr_d;
      clr_cnt_q <= clr_cnt_d;
    end
  end

  // Storage: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (clr_q) begin
      mem_q[clr_cnt_q] <= '0;
    end else if (wr_i.en) begin
      mem_q[wr_i.idx[IdxW-1:0]] <= wr_i.data;
    end
    if (rd_en_i) begin
      rd_q     <= mem_q[rd_idx_i[IdxW-1:0]];
      rd_idx_q <= rd_idx_i[IdxW-1:0];
    end
  end

  // Last write, covers a read issued on the same edge as that write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_vld_q <= 1'b0;
    end else if (wr_i.en) begin
      fwd_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      fwd_idx_q  <= wr_i.idx[IdxW-1:0];
      fwd_data_q <= wr_i.data;
    end
  end

  assign rd_data_o  = (fwd_vld_q && (fwd_idx_q == rd_idx_q)) ? fwd_data_q : rd_q;
  assign clearing_o = clr_q;

endmodule

FILE: rtl/core/plc_eval.sv
module plc_eval (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s1_vld_i,
  input  plc_pkg::plc_s1_t                s1_i,
  input  logic [plc_pkg::POS_W-1:0]       old_pos_i,
  input  logic [plc_pkg::NET_LIM_W-1:0]   net_limit_i,
  input  logic [plc_pkg::NOTL_LIM_W-1:0]  notional_limit_i,
  output logic                            adv_o,
  output plc_pkg::plc_wr_t                wr_o,
  plc_rsp_if.source                       rsp_o
);

  logic                            out_vld_q;
  logic                            acc_q;
  logic [plc_pkg::POS_W-1:0]       pos_q;

  logic                            acc_d;
  logic [plc_pkg::POS_W-1:0]       pos_d;
  logic                            wr_d;
  logic [plc_pkg::SUM_W-1:0]       old_x, qty_x, lim_x, sum;
  logic [plc_pkg::POS_W-1:0]       cancel_pos;
  logic                            notional_fail, over, under;

  // Limit arithmetic
  always_comb begin
    old_x         = {{2{old_pos_i[plc_pkg::POS_W-1]}}, old_pos_i};
    qty_x         = plc_pkg::SUM_W'(s1_i.qty);
    lim_x         = plc_pkg::SUM_W'(net_limit_i);
    sum           = s1_i.sell ? (old_x - qty_x) : (old_x + qty_x);
    over          = $signed(sum) > $signed(lim_x);
    under         = $signed(sum) < -$signed(lim_x);
    notional_fail = s1_i.notional_chk &&
                    (plc_pkg::NOTL_LIM_W'(s1_i.product) > notional_limit_i);
    cancel_pos    = s1_i.sell ? (old_pos_i + plc_pkg::POS_W'(s1_i.qty))
                              : (old_pos_i - plc_pkg::POS_W'(s1_i.qty));
  end

  // Operation decode
  always_comb begin
    acc_d = 1'b0;
    pos_d = '0;
    wr_d  = 1'b0;
    if (s1_i.in_range) begin
      case (plc_pkg::plc_op_e'(s1_i.op))
        plc_pkg::OP_RESERVE: begin
          if (!notional_fail && !over && !under) begin
            acc_d = 1'b1;
            pos_d = sum[plc_pkg::POS_W-1:0];
            wr_d  = 1'b1;
          end else begin
            pos_d = old_pos_i;
          end
        end
        plc_pkg::OP_CANCEL: begin
          acc_d = 1'b1;
          pos_d = cancel_pos;
          wr_d  = 1'b1;
        end
        plc_pkg::OP_QUERY: begin
          acc_d = 1'b1;
          pos_d = old_pos_i;
        end
        default: begin
          acc_d = 1'b0;
          pos_d = '0;
        end
      endcase
    end
  end

  // Item leaves evaluation when the output register is free
  assign adv_o    = s1_vld_i && (!out_vld_q || rsp_o.ready);
  assign wr_o.en   = adv_o && wr_d;
  assign wr_o.idx  = s1_i.idx;
  assign wr_o.data = pos_d;

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv_o) begin
      out_vld_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      acc_q <= acc_d;
      pos_q <= pos_d;
    end
  end

  assign rsp_o.valid    = out_vld_q;
  assign rsp_o.accepted = acc_q;
  assign rsp_o.position = pos_q;

endmodule

FILE: rtl/core/position_limit_check.sv
// Pipeline: the edge that accepts a request loads the input register and reads the
// table; the result is registered in the output register once that register is free.
// Throughput: one request per cycle while rsp_o.ready is high; the single table
// read-modify-write per request is closed by forwarding the last write.
// Reset: asynchronous, active low; afterwards the table is cleared one entry per
// cycle, with req_i.ready low; config writes are taken.
module position_limit_check #(
  parameter int unsigned NumInstruments = plc_pkg::NUM_INSTRUMENTS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [plc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [plc_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  plc_req_if.sink                         req_i,
  plc_rsp_if.source                       rsp_o
);

  logic [plc_pkg::NET_LIM_W-1:0]  net_limit_q;
  logic [plc_pkg::NOTL_LIM_W-1:0] notional_limit_q;

  logic                           s1_vld_q;
  plc_pkg::plc_s1_t               s1_q, s1_d;
  logic                           req_acc;
  logic                           s1_adv;
  logic                           clearing;
  logic [plc_pkg::POS_W-1:0]      old_pos;
  plc_pkg::plc_wr_t               wr;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      net_limit_q      <= '0;
      notional_limit_q <= '0;
    end else if (cfg_we_i) begin
      case (plc_pkg::plc_cfg_e'(cfg_idx_i))
        plc_pkg::CFG_NET_LIMIT:      net_limit_q      <= cfg_data_i[plc_pkg::NET_LIM_W-1:0];
        plc_pkg::CFG_NOTIONAL_LIMIT: notional_limit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign req_i.ready = !clearing && (!s1_vld_q || s1_adv);
  assign req_acc     = req_i.valid && req_i.ready;

  // Request decode and notional product
  always_comb begin
    s1_d.op           = req_i.operation;
    s1_d.in_range     = {1'b0, req_i.instrument} <
                        (plc_pkg::INSTR_W + 1)'(NumInstruments);
    s1_d.idx          = req_i.instrument;
    s1_d.sell         = req_i.side;
    s1_d.qty          = req_i.quantity;
    s1_d.notional_chk = !req_i.price[plc_pkg::PRICE_W-1] && (req_i.price != '0) &&
                        (req_i.quantity != '0);
    s1_d.product      = plc_pkg::PROD_W'(req_i.price[plc_pkg::PRICE_W-2:0]) *
                        plc_pkg::PROD_W'(req_i.quantity);
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (req_acc) begin
      s1_vld_q <= 1'b1;
    end else if (s1_adv) begin
      s1_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      s1_q <= s1_d;
    end
  end

  plc_table #(
    .NumInstruments(NumInstruments)
  ) u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (req_acc),
    .rd_idx_i   (req_i.instrument),
    .wr_i       (wr),
    .clearing_o (clearing),
    .rd_data_o  (old_pos)
  );

  plc_eval u_eval (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .s1_vld_i         (s1_vld_q),
    .s1_i             (s1_q),
    .old_pos_i        (old_pos),
    .net_limit_i      (net_limit_q),
    .notional_limit_i (notional_limit_q),
    .adv_o            (s1_adv),
    .wr_o             (wr),
    .rsp_o            (rsp_o)
  );

endmodule
